// ===== hw/rtl/first_fit_heap_allocator_core_assert.svh =====
// Assertion macros for the first-fit heap allocator core.
// Used by the modules that check their own control logic; needs clk and rst in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define FFHA_AT_ONCE(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffha check failed");

// next-cycle implication
`define FFHA_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffha check failed");

`endif

// ===== hw/rtl/ffha_pkg.sv =====
// Shared constants, types and state codes of the first-fit heap allocator.
// No dependencies; imported by every module of the block.
package ffha_pkg;

  localparam int unsigned REGION_BYTES_MAX = 65536;
  localparam int unsigned HEADER_BYTES     = 4;
  localparam int unsigned NODE_BYTES       = 8;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned CFG_W  = 17;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FA_W   = 20;
  localparam int unsigned LEN_W  = 17;
  localparam int unsigned CUR_W  = 18;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  localparam logic [LEN_W-1:0] LEN_BYTE = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_WORD = LEN_W'(HEADER_BYTES);
  localparam logic [LEN_W-1:0] LEN_ALL  = LEN_W'(REGION_BYTES_MAX);

  typedef enum logic [1:0] {
    FOP_RD,
    FOP_WR,
    FOP_CLR
  } fop_t;

  typedef struct packed {
    logic              go;
    fop_t              op;
    logic [FA_W-1:0]   addr;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] wdata;
  } fu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] rdata;
  } fu_rsp_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  typedef enum logic [5:0] {
    S_IDLE, S_CLEAR, S_INIT,
    S_ASTART, S_ARSZ, S_ARLK, S_ACHK, S_AS1, S_AS2, S_AS3, S_AS4, S_AMARK,
    S_AREM, S_AT1, S_AT2, S_AT3, S_ALINK, S_APREV,
    S_LMARK,
    S_RWCHK, S_RWLINK, S_RSETLK, S_RPSZ, S_RNSZ, S_RPWSZ, S_RPLINK,
    S_RTAIL, S_RTPSZ, S_RTCLK, S_RTWLK, S_RTPSZ2, S_RTCSZ, S_RTWSZ,
    S_QSZ,
    S_DONE
  } ctl_state_t;

endpackage

// ===== hw/rtl/ffha_ram.sv =====
// Byte-wide region memory, one access per cycle, registered read data.
// Depends on ffha_pkg.
module ffha_ram import ffha_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [REGION_BYTES_MAX];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== hw/rtl/ffha_field.sv =====
// Field access unit: reads or writes big-endian multi-byte fields, one byte a cycle,
// and sweeps the region to zero. Depends on ffha_pkg; drives ffha_ram.
module ffha_field import ffha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  fu_req_t    req,
  output fu_rsp_t    rsp,
  output ram_req_t   ram,
  input  logic [7:0] ram_rdata
);

  logic              busy;
  fop_t              op;
  logic [FA_W-1:0]   addr;
  logic [LEN_W-1:0]  cnt;
  logic [WORD_W-1:0] shreg;
  logic [WORD_W-1:0] acc;
  logic              pend;
  logic              pend_in;
  logic              issue;
  logic              in_rng;

  always_comb begin
    issue     = busy && (cnt != '0);
    in_rng    = (addr[FA_W-1:ADDR_W] == '0);
    ram.addr  = addr[ADDR_W-1:0];
    ram.we    = issue && (op != FOP_RD) && in_rng;
    ram.re    = issue && (op == FOP_RD) && in_rng;
    ram.wdata = shreg[WORD_W-1:WORD_W-8];
    rsp.busy  = busy;
    rsp.done  = busy && (cnt == '0) && !pend;
    rsp.rdata = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
    end else begin
      pend <= issue && (op == FOP_RD);
      if (!busy && req.go) begin
        busy <= 1'b1;
      end else if (rsp.done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_in <= in_rng;
    if (!busy && req.go) begin
      op   <= req.op;
      addr <= req.addr;
      cnt  <= req.len;
      acc  <= '0;
      if (req.op == FOP_WR) begin
        shreg <= (req.len == LEN_BYTE) ? {req.wdata[7:0], 24'h0} : req.wdata;
      end else begin
        shreg <= '0;
      end
    end else begin
      if (issue) begin
        addr  <= addr + FA_W'(1);
        cnt   <= cnt - LEN_W'(1);
        shreg <= {shreg[WORD_W-9:0], 8'h0};
      end
      if (pend) begin
        acc <= {acc[WORD_W-9:0], (pend_in ? ram_rdata : 8'h0)};
      end
    end
  end

endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// Sequencer of the allocator: free-list walk, split, merge and query over the field unit.
// Depends on ffha_pkg and first_fit_heap_allocator_core_assert.svh.
`include "first_fit_heap_allocator_core_assert.svh"
module ffha_ctrl import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output fu_req_t     fu_req,
  input  fu_rsp_t     fu_rsp
);

  ctl_state_t state, state_next;

  logic [CFG_W-1:0]  region, region_next;
  logic [WORD_W-1:0] head, head_next;
  logic              hvalid, hvalid_next;
  logic              issued, issued_next;
  logic              out_valid, out_valid_next;

  logic [1:0]        act, act_next;
  logic [15:0]       req, req_next;
  logic [2:0]        alog, alog_next;
  logic [15:0]       ptr, ptr_next;
  logic [CUR_W-1:0]  cur, cur_next;
  logic [CUR_W-1:0]  prev, prev_next;
  logic              has_prev, has_prev_next;
  logic              have, have_next;
  logic [WORD_W-1:0] csz, csz_next;
  logic [WORD_W-1:0] link, link_next;
  logic [16:0]       need, need_next;
  logic [6:0]        shift, shift_next;
  logic [WORD_W-1:0] size, size_next;
  logic [WORD_W-1:0] rem, rem_next;
  logic              split, split_next;
  logic [CUR_W-1:0]  t, t_next;
  logic [15:0]       node, node_next;
  logic [WORD_W-1:0] ps, ps_next;
  logic [WORD_W-1:0] ns, ns_next;
  logic [15:0]       res_addr, res_addr_next;
  logic              res_fail, res_fail_next;
  logic [15:0]       res_use, res_use_next;
  logic [31:0]       out_data, out_data_next;
  logic              out_fail, out_fail_next;

  logic              s_acc, c_acc, done, mem_st, load;
  logic [WORD_W-1:0] rd;
  fop_t              f_op;
  logic [FA_W-1:0]   f_addr;
  logic [LEN_W-1:0]  f_len;
  logic [WORD_W-1:0] f_wdata;

  logic [CFG_W-1:0]  cfg_sat;
  logic [16:0]       req_rnd;
  logic [16:0]       need_c;
  logic [6:0]        al_mask;
  logic [CUR_W-1:0]  data_c;
  logic [6:0]        shift_c;
  logic [32:0]       need_sh;
  logic              fit, lk_ok, rd_lk_ok, head_ok, walk_go, absorb;
  logic [8:0]        back;
  logic              loc_ok;
  logic [15:0]       node_c;
  logic [33:0]       prev_plus_rd;
  logic [CUR_W-1:0]  nn;
  logic [WORD_W-1:0] rem_c;
  logic [WORD_W-1:0] rd_use;

  assign done  = fu_rsp.done;
  assign rd    = fu_rsp.rdata;
  assign s_acc = s_tvalid && s_tready;
  assign c_acc = cfg_valid && cfg_ready;
  assign load  = (state == S_DONE) && (!out_valid || m_tready);

  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign m_tuser   = out_fail;

  always_comb begin
    cfg_sat = (cfg_data > CFG_W'(REGION_BYTES_MAX)) ? CFG_W'(REGION_BYTES_MAX) : cfg_data;
    cfg_sat[0] = 1'b0;
    req_rnd = 17'(req) + 17'd1;
    need_c  = {req_rnd[16:1], 1'b0} + 17'(HEADER_BYTES);
    if (need_c < 17'(NODE_BYTES)) begin
      need_c = 17'(NODE_BYTES);
    end
    al_mask  = 7'((8'd1 << alog) - 8'd1);
    data_c   = cur + CUR_W'(HEADER_BYTES);
    shift_c  = (7'd0 - data_c[6:0]) & al_mask;
    need_sh  = 33'(need) + 33'(shift);
    fit      = need_sh <= 33'(csz);
    lk_ok    = (link > 32'(cur)) && (33'(link) + 33'(NODE_BYTES) <= 33'(region));
    rd_lk_ok = (rd > 32'(cur)) && (33'(rd) + 33'(NODE_BYTES) <= 33'(region));
    head_ok  = hvalid && (33'(head) + 33'(NODE_BYTES) <= 33'(region));
    walk_go  = have && (cur <= CUR_W'(node));
    back     = rd[0] ? (9'(rd[7:0]) + 9'(HEADER_BYTES) - 9'd1) : 9'(HEADER_BYTES);
    node_c   = ptr - 16'(back);
    loc_ok   = (17'(ptr) >= 17'(back)) &&
               (17'(node_c) + 17'(NODE_BYTES) <= region);
    prev_plus_rd = 34'(prev) + 34'(rd);
    nn       = cur + CUR_W'(shift);
    rem_c    = csz - size;
    absorb   = rem_c < WORD_W'(NODE_BYTES);
    rd_use   = rd - WORD_W'(HEADER_BYTES);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (c_acc) begin
          state_next = S_CLEAR;
        end else if (s_acc) begin
          case (s_tuser)
            ACT_ALLOC:   state_next = S_ASTART;
            ACT_RELEASE: state_next = S_LMARK;
            ACT_QUERY:   state_next = S_LMARK;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR:  if (done) state_next = hvalid ? S_INIT : S_IDLE;
      S_INIT:   if (done) state_next = S_IDLE;
      S_ASTART: state_next = ((req == '0) || !head_ok) ? S_DONE : S_ARSZ;
      S_ARSZ:   if (done) state_next = S_ARLK;
      S_ARLK:   if (done) state_next = S_ACHK;
      S_ACHK: begin
        if (fit) begin
          if (shift >= 7'(NODE_BYTES)) begin
            state_next = S_AS1;
          end else if (shift != '0) begin
            state_next = S_AMARK;
          end else begin
            state_next = S_AREM;
          end
        end else begin
          state_next = lk_ok ? S_ARSZ : S_DONE;
        end
      end
      S_AS1:    if (done) state_next = S_AS2;
      S_AS2:    if (done) state_next = S_AS3;
      S_AS3:    if (done) state_next = S_AS4;
      S_AS4:    if (done) state_next = S_AREM;
      S_AMARK:  if (done) state_next = S_AREM;
      S_AREM:   state_next = absorb ? S_ALINK : S_AT1;
      S_AT1:    if (done) state_next = S_AT2;
      S_AT2:    if (done) state_next = S_AT3;
      S_AT3:    if (done) state_next = S_ALINK;
      S_ALINK:  state_next = has_prev ? S_APREV : S_DONE;
      S_APREV:  if (done) state_next = S_DONE;
      S_LMARK: begin
        if (done) begin
          if (!loc_ok) begin
            state_next = S_DONE;
          end else begin
            state_next = (act == ACT_RELEASE) ? S_RWCHK : S_QSZ;
          end
        end
      end
      S_RWCHK:  state_next = walk_go ? S_RWLINK : S_RSETLK;
      S_RWLINK: if (done) state_next = S_RWCHK;
      S_RSETLK: if (done) state_next = has_prev ? S_RPSZ : S_RTAIL;
      S_RPSZ:   if (done) state_next = (prev_plus_rd == 34'(node)) ? S_RNSZ : S_RPLINK;
      S_RNSZ:   if (done) state_next = S_RPWSZ;
      S_RPWSZ:  if (done) state_next = S_RTAIL;
      S_RPLINK: if (done) state_next = S_RTAIL;
      S_RTAIL:  state_next = have ? S_RTPSZ : S_DONE;
      S_RTPSZ:  if (done) state_next = (prev_plus_rd == 34'(cur)) ? S_RTCLK : S_DONE;
      S_RTCLK:  if (done) state_next = S_RTWLK;
      S_RTWLK:  if (done) state_next = S_RTPSZ2;
      S_RTPSZ2: if (done) state_next = S_RTCSZ;
      S_RTCSZ:  if (done) state_next = S_RTWSZ;
      S_RTWSZ:  if (done) state_next = S_DONE;
      S_QSZ:    if (done) state_next = S_DONE;
      S_DONE:   if (load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // field unit requests
  always_comb begin
    mem_st  = 1'b1;
    f_op    = FOP_RD;
    f_addr  = '0;
    f_len   = LEN_WORD;
    f_wdata = '0;
    case (state)
      S_CLEAR:  begin f_op = FOP_CLR; f_len = LEN_ALL; end
      S_INIT:   begin f_op = FOP_WR; f_wdata = 32'(region); end
      S_ARSZ:   f_addr = 20'(cur);
      S_ARLK:   f_addr = 20'(cur) + 20'(HEADER_BYTES);
      S_AS1:    begin f_op = FOP_WR; f_addr = 20'(nn); f_wdata = csz - 32'(shift); end
      S_AS2: begin
        f_op = FOP_WR; f_addr = 20'(nn) + 20'(HEADER_BYTES); f_wdata = link;
      end
      S_AS3:    begin f_op = FOP_WR; f_addr = 20'(cur); f_wdata = 32'(shift); end
      S_AS4: begin
        f_op = FOP_WR; f_addr = 20'(cur) + 20'(HEADER_BYTES); f_wdata = 32'(nn);
      end
      S_AMARK: begin
        f_op    = FOP_WR;
        f_len   = LEN_BYTE;
        f_addr  = 20'(cur) + 20'(HEADER_BYTES) + 20'(shift) - 20'd1;
        f_wdata = 32'(shift | 7'd1);
      end
      S_AT1: begin
        f_op = FOP_WR; f_addr = 20'(t) + 20'(HEADER_BYTES); f_wdata = link;
      end
      S_AT2:    begin f_op = FOP_WR; f_addr = 20'(t); f_wdata = rem; end
      S_AT3:    begin f_op = FOP_WR; f_addr = 20'(cur); f_wdata = size; end
      S_APREV: begin
        f_op    = FOP_WR;
        f_addr  = 20'(prev) + 20'(HEADER_BYTES);
        f_wdata = split ? 32'(t) : link;
      end
      S_LMARK:  begin f_addr = 20'(ptr) - 20'd1; f_len = LEN_BYTE; end
      S_RWLINK: f_addr = 20'(cur) + 20'(HEADER_BYTES);
      S_RSETLK: begin
        f_op    = FOP_WR;
        f_addr  = 20'(node) + 20'(HEADER_BYTES);
        f_wdata = have ? 32'(cur) : '0;
      end
      S_RPSZ:   f_addr = 20'(prev);
      S_RNSZ:   f_addr = 20'(node);
      S_RPWSZ:  begin f_op = FOP_WR; f_addr = 20'(prev); f_wdata = ps + ns; end
      S_RPLINK: begin
        f_op = FOP_WR; f_addr = 20'(prev) + 20'(HEADER_BYTES); f_wdata = 32'(node);
      end
      S_RTPSZ:  f_addr = 20'(prev);
      S_RTCLK:  f_addr = 20'(cur) + 20'(HEADER_BYTES);
      S_RTWLK: begin
        f_op = FOP_WR; f_addr = 20'(prev) + 20'(HEADER_BYTES); f_wdata = link;
      end
      S_RTPSZ2: f_addr = 20'(prev);
      S_RTCSZ:  f_addr = 20'(cur);
      S_RTWSZ:  begin f_op = FOP_WR; f_addr = 20'(prev); f_wdata = ps + ns; end
      S_QSZ:    f_addr = 20'(node);
      default:  mem_st = 1'b0;
    endcase
    fu_req.go    = mem_st && !issued && !fu_rsp.busy;
    fu_req.op    = f_op;
    fu_req.addr  = f_addr;
    fu_req.len   = f_len;
    fu_req.wdata = f_wdata;
  end

  // register updates
  always_comb begin
    region_next   = region;
    head_next     = head;
    hvalid_next   = hvalid;
    issued_next   = issued;
    act_next      = act;
    req_next      = req;
    alog_next     = alog;
    ptr_next      = ptr;
    cur_next      = cur;
    prev_next     = prev;
    has_prev_next = has_prev;
    have_next     = have;
    csz_next      = csz;
    link_next     = link;
    need_next     = need;
    shift_next    = shift;
    size_next     = size;
    rem_next      = rem;
    split_next    = split;
    t_next        = t;
    node_next     = node;
    ps_next       = ps;
    ns_next       = ns;
    res_addr_next = res_addr;
    res_fail_next = res_fail;
    res_use_next  = res_use;
    out_data_next = out_data;
    out_fail_next = out_fail;
    out_valid_next = out_valid && !m_tready;

    if (fu_req.go) begin
      issued_next = 1'b1;
    end else if (done) begin
      issued_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (c_acc) begin
          region_next = cfg_sat;
          head_next   = '0;
          hvalid_next = cfg_sat >= CFG_W'(NODE_BYTES);
        end else if (s_acc) begin
          act_next      = s_tuser;
          req_next      = s_tdata[15:0];
          alog_next     = s_tdata[18:16];
          ptr_next      = s_tdata[34:19];
          res_addr_next = '0;
          res_fail_next = 1'b0;
          res_use_next  = '0;
        end
      end
      S_ASTART: begin
        need_next     = need_c;
        cur_next      = CUR_W'(head);
        has_prev_next = 1'b0;
        if ((req == '0) || !head_ok) begin
          res_fail_next = 1'b1;
        end
      end
      S_ARSZ: if (done) begin csz_next = rd; shift_next = shift_c; end
      S_ARLK: if (done) link_next = rd;
      S_ACHK: begin
        if (fit) begin
          size_next = (shift >= 7'(NODE_BYTES)) ? 32'(need) : 32'(need_sh);
        end else begin
          has_prev_next = 1'b1;
          prev_next     = cur;
          if (lk_ok) begin
            cur_next = CUR_W'(link);
          end else begin
            res_fail_next = 1'b1;
          end
        end
      end
      S_AS4: begin
        if (done) begin
          prev_next     = cur;
          has_prev_next = 1'b1;
          cur_next      = nn;
          csz_next      = csz - 32'(shift);
          shift_next    = '0;
        end
      end
      S_AREM: begin
        t_next = cur + CUR_W'(size);
        if (absorb) begin
          size_next  = csz;
          rem_next   = '0;
          split_next = 1'b0;
        end else begin
          rem_next   = rem_c;
          split_next = 1'b1;
        end
      end
      S_ALINK: begin
        res_addr_next = 16'(cur + CUR_W'(HEADER_BYTES) + CUR_W'(shift));
        if (!has_prev) begin
          head_next   = split ? 32'(t) : link;
          hvalid_next = split || (link != '0);
        end
      end
      S_LMARK: begin
        if (done) begin
          node_next     = node_c;
          have_next     = head_ok;
          cur_next      = CUR_W'(head);
          has_prev_next = 1'b0;
        end
      end
      S_RWCHK: begin
        if (walk_go) begin
          has_prev_next = 1'b1;
          prev_next     = cur;
        end
      end
      S_RWLINK: begin
        if (done) begin
          have_next = rd_lk_ok;
          if (rd_lk_ok) begin
            cur_next = CUR_W'(rd);
          end
        end
      end
      S_RSETLK: begin
        if (done && !has_prev) begin
          head_next   = 32'(node);
          hvalid_next = 1'b1;
          prev_next   = CUR_W'(node);
        end
      end
      S_RPSZ:   if (done) ps_next = rd;
      S_RNSZ:   if (done) ns_next = rd;
      S_RPLINK: if (done) prev_next = CUR_W'(node);
      S_RTCLK:  if (done) link_next = rd;
      S_RTPSZ2: if (done) ps_next = rd;
      S_RTCSZ:  if (done) ns_next = rd;
      S_QSZ: begin
        if (done) begin
          if (rd < WORD_W'(HEADER_BYTES)) begin
            res_use_next = '0;
          end else if (rd_use > 32'h0000_FFFF) begin
            res_use_next = 16'hFFFF;
          end else begin
            res_use_next = rd_use[15:0];
          end
        end
      end
      S_DONE: begin
        if (load) begin
          out_valid_next = 1'b1;
          out_data_next  = {res_use, res_addr};
          out_fail_next  = res_fail;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      region    <= CFG_W'(REGION_BYTES_MAX);
      head      <= '0;
      hvalid    <= 1'b1;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      region    <= region_next;
      head      <= head_next;
      hvalid    <= hvalid_next;
      issued    <= issued_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act      <= act_next;
    req      <= req_next;
    alog     <= alog_next;
    ptr      <= ptr_next;
    cur      <= cur_next;
    prev     <= prev_next;
    has_prev <= has_prev_next;
    have     <= have_next;
    csz      <= csz_next;
    link     <= link_next;
    need     <= need_next;
    shift    <= shift_next;
    size     <= size_next;
    rem      <= rem_next;
    split    <= split_next;
    t        <= t_next;
    node     <= node_next;
    ps       <= ps_next;
    ns       <= ns_next;
    res_addr <= res_addr_next;
    res_fail <= res_fail_next;
    res_use  <= res_use_next;
    out_data <= out_data_next;
    out_fail <= out_fail_next;
  end

  `FFHA_AT_ONCE(a_go_idle_unit, fu_req.go, !fu_rsp.busy)
  `FFHA_AT_ONCE(a_done_issued, fu_rsp.done, issued)
  `FFHA_NEXT(a_cfg_clear, c_acc, state == S_CLEAR)
  `FFHA_NEXT(a_item_busy, s_acc, state != S_IDLE)
  `FFHA_AT_ONCE(a_accept_ready, s_acc, !c_acc)

endmodule

// ===== hw/rtl/first_fit_heap_allocator_core.sv =====
// Top level of the first-fit heap allocator: region memory, field unit and sequencer.
// Depends on ffha_pkg, ffha_ram, ffha_field and ffha_ctrl.
//
//   channel  | direction | handshake          | payload
//   s_*      | in        | s_tvalid/s_tready  | request item
//   m_*      | out       | m_tvalid/m_tready  | result item
//   cfg_*    | in        | cfg_valid/cfg_ready| region_bytes
//
// Every memory access goes through the field unit, one byte per cycle. Allocate visits free
// blocks in turn and then splits and relinks; release walks the free list and then merges.
// After reset and after each region_bytes write a clearing pass zeroes the region and then
// writes the header if the region holds a node; no item is taken meanwhile.
// A result waiting on m_tready does not stop the next item from being taken.
module first_fit_heap_allocator_core import ffha_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [39:0]      s_tdata,   // request_bytes[15:0], align_log2[18:16], block_addr[34:19]
  input  logic [1:0]       s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // result_addr[15:0], usable_bytes[31:16]
  output logic             m_tuser,   // failed
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  fu_req_t    fu_req;
  fu_rsp_t    fu_rsp;
  ram_req_t   ram_req;
  logic [7:0] ram_rdata;

  ffha_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  ffha_field u_field (
    .clk       (clk),
    .rst       (rst),
    .req       (fu_req),
    .rsp       (fu_rsp),
    .ram       (ram_req),
    .ram_rdata (ram_rdata)
  );

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fu_req    (fu_req),
    .fu_rsp    (fu_rsp)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_heap_allocator_core: allocate, release and size
// query items are checked against an in-bench heap predictor. Depends on ffha_pkg.
module tb_top;
  import ffha_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] req;
    logic [2:0]  align;
    logic [15:0] addr;
  } heap_req_t;

  typedef struct {
    logic [15:0] addr;
    logic        failed;
    logic [15:0] usable;
  } heap_rsp_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  bit [7:0] heap_mem [REGION_BYTES_MAX];
  longint region_len;
  longint free_head;
  bit head_ok;

  heap_rsp_t pending_results[$];
  logic [15:0] live_blocks[$];
  int mismatches = 0;
  bit steady_flow = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  first_fit_heap_allocator_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint rd_be(longint a, int n);
    longint v;
    v = 0;
    for (int i = 0; i < n; i++)
      v = (v << 8) | ((a + i < REGION_BYTES_MAX) ? longint'(heap_mem[a + i]) : 0);
    return v;
  endfunction

  function automatic void wr_be(longint a, int n, longint v);
    for (int i = 0; i < n; i++)
      if (a + i < REGION_BYTES_MAX) heap_mem[a + i] = 8'(v >> (8 * (n - 1 - i)));
  endfunction

  function automatic longint blk_size(longint a);
    return rd_be(a, HEADER_BYTES);
  endfunction

  function automatic longint blk_link(longint a);
    return rd_be(a + HEADER_BYTES, NODE_BYTES - HEADER_BYTES);
  endfunction

  function automatic void set_size(longint a, longint v);
    wr_be(a, HEADER_BYTES, v);
  endfunction

  function automatic void set_link(longint a, longint v);
    wr_be(a + HEADER_BYTES, NODE_BYTES - HEADER_BYTES, v);
  endfunction

  function automatic bit node_fits(longint a);
    return a + NODE_BYTES <= region_len;
  endfunction

  function automatic bit next_free(longint a, output longint nxt);
    longint l;
    l = blk_link(a);
    nxt = l;
    return (l > a) && node_fits(l);
  endfunction

  function automatic bit header_of(longint ptr, output longint node);
    longint mark, back;
    mark = 0;
    back = HEADER_BYTES;
    node = 0;
    if (ptr >= 1) mark = heap_mem[ptr - 1];
    if (mark & 1) back += mark - 1;
    if (ptr < back) return 0;
    node = ptr - back;
    return node_fits(node);
  endfunction

  function automatic void heap_rebuild(longint value);
    longint v;
    v = value & 'h1FFFF;
    if (v > REGION_BYTES_MAX) v = REGION_BYTES_MAX;
    region_len = v & ~longint'(1);
    foreach (heap_mem[i]) heap_mem[i] = 0;
    free_head = 0;
    head_ok = region_len >= NODE_BYTES;
    if (head_ok) begin
      set_size(0, region_len);
      set_link(0, 0);
    end
  endfunction

  function automatic bit heap_alloc(longint req, longint alog, output longint addr);
    longint need, al, prev, cur, csz, data, shift, sz, link, rem, repl, t;
    bit has_prev, have, split;
    addr = 0;
    prev = 0;
    has_prev = 0;
    if (req == 0) return 0;
    need = ((req + 1) & ~longint'(1)) + HEADER_BYTES;
    if (need < NODE_BYTES) need = NODE_BYTES;
    al = alog ? (longint'(1) << alog) : 0;
    cur = free_head;
    have = head_ok && node_fits(free_head);
    while (have) begin
      csz = blk_size(cur);
      data = cur + HEADER_BYTES;
      shift = al ? ((al - (data & (al - 1))) & (al - 1)) : 0;
      sz = need;
      if (sz + shift <= csz) begin
        link = blk_link(cur);
        if (shift >= NODE_BYTES) begin
          set_size(cur + shift, csz - shift);
          set_link(cur + shift, link);
          set_size(cur, shift);
          set_link(cur, cur + shift);
          has_prev = 1;
          prev = cur;
          cur = cur + shift;
          csz -= shift;
          shift = 0;
          data = cur + HEADER_BYTES;
        end else if (shift > 0) begin
          wr_be(data + shift - 1, 1, shift | 1);
          sz += shift;
        end
        rem = csz - sz;
        if (rem < NODE_BYTES) begin
          sz += rem;
          rem = 0;
        end
        split = sz < csz;
        if (split) begin
          t = cur + sz;
          set_link(t, link);
          set_size(t, rem);
          set_size(cur, sz);
          repl = t;
        end else begin
          repl = link;
        end
        if (has_prev) begin
          set_link(prev, repl);
        end else begin
          free_head = repl;
          head_ok = split || repl != 0;
        end
        addr = data + shift;
        return 1;
      end
      has_prev = 1;
      prev = cur;
      have = next_free(cur, cur);
    end
    return 0;
  endfunction

  function automatic void heap_release(longint ptr);
    longint node, prev, cur;
    bit has_prev, have;
    prev = 0;
    has_prev = 0;
    if (!header_of(ptr, node)) return;
    cur = free_head;
    have = head_ok && node_fits(free_head);
    while (have && cur <= node) begin
      has_prev = 1;
      prev = cur;
      have = next_free(cur, cur);
    end
    set_link(node, have ? cur : 0);
    if (has_prev) begin
      if (prev + blk_size(prev) == node) begin
        set_size(prev, blk_size(prev) + blk_size(node));
      end else begin
        set_link(prev, node);
        prev = node;
      end
    end else begin
      free_head = node;
      head_ok = 1;
      prev = node;
    end
    if (have && prev + blk_size(prev) == cur) begin
      set_link(prev, blk_link(cur));
      set_size(prev, blk_size(prev) + blk_size(cur));
    end
  endfunction

  function automatic longint heap_usable(longint ptr);
    longint node, sz;
    if (!header_of(ptr, node)) return 0;
    sz = blk_size(node);
    if (sz < HEADER_BYTES) return 0;
    sz -= HEADER_BYTES;
    return (sz > 'hFFFF) ? 'hFFFF : sz;
  endfunction

  function automatic heap_rsp_t predict_result(heap_req_t it);
    heap_rsp_t r;
    longint a;
    r.addr = '0;
    r.failed = 0;
    r.usable = '0;
    case (it.action)
      ACT_ALLOC: begin
        if (heap_alloc(it.req, it.align, a)) begin
          r.addr = 16'(a);
          live_blocks.push_back(16'(a));
        end else begin
          r.failed = 1;
        end
      end
      ACT_RELEASE: heap_release(it.addr);
      ACT_QUERY: r.usable = 16'(heap_usable(it.addr));
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(heap_req_t it);
    s_tvalid <= 1;
    s_tdata <= {5'b0, it.addr, it.align, it.req};
    s_tuser <= it.action;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_result(it));
    if (!steady_flow && $urandom_range(99) < 37) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_op(logic [1:0] act, int req, int alog, int addr);
    heap_req_t it;
    it.action = act;
    it.req = 16'(req);
    it.align = 3'(alog);
    it.addr = 16'(addr);
    send_item(it);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_region(logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    heap_rebuild(value);
    live_blocks.delete();
  endtask

  task automatic random_item(int max_req);
    int r, k;
    r = $urandom_range(99);
    if (r < 4) begin
      send_op(2'($urandom), $urandom, $urandom, $urandom);
    end else if (live_blocks.size() != 0 && (r < 40 || live_blocks.size() > 24)) begin
      k = $urandom_range(live_blocks.size() - 1);
      send_op(ACT_RELEASE, $urandom, $urandom, live_blocks[k]);
      live_blocks.delete(k);
    end else if (live_blocks.size() != 0 && r < 52) begin
      send_op(ACT_QUERY, $urandom, $urandom, live_blocks[$urandom_range(live_blocks.size() - 1)]);
    end else begin
      k = $urandom_range(99);
      if (k < 70) k = $urandom_range(1, 48);
      else if (k < 92) k = $urandom_range(1, 600);
      else if (k < 98) k = $urandom_range(1, max_req);
      else k = $urandom_range(0, 65535);
      send_op(ACT_ALLOC, k, $urandom_range(0, 7), $urandom);
    end
  endtask

  task automatic test_directed;
    send_op(ACT_ALLOC, 0, 0, 0);
    send_op(ACT_ALLOC, 65535, 7, 16'hFFFF);
    send_op(ACT_ALLOC, 1, 0, 0);
    send_op(ACT_ALLOC, 3, 2, 0);
    send_op(ACT_ALLOC, 10, 1, 0);
    send_op(ACT_ALLOC, 5, 7, 0);
    send_op(ACT_ALLOC, 7, 4, 0);
    send_op(ACT_QUERY, 0, 0, live_blocks[1]);
    send_op(ACT_QUERY, 0, 0, 0);
    send_op(ACT_QUERY, 0, 0, 16'hFFFF);
    send_op(ACT_RELEASE, 0, 0, 2);
    send_op(ACT_RELEASE, 0, 0, live_blocks[1]);
    send_op(ACT_RELEASE, 0, 0, live_blocks[2]);
    send_op(ACT_RELEASE, 0, 0, live_blocks[0]);
    send_op(2'd3, 16'hFFFF, 7, 16'hFFFF);
    send_op(ACT_ALLOC, 65000, 0, 0);
    send_op(ACT_QUERY, 0, 0, live_blocks[live_blocks.size() - 1]);
    send_op(ACT_RELEASE, 0, 0, live_blocks[3]);
    send_op(ACT_RELEASE, 0, 0, live_blocks[4]);
    send_op(ACT_QUERY, 0, 0, live_blocks[3]);
    live_blocks.delete();
  endtask

  task automatic test_tiny_regions;
    write_region(17'd16);
    send_op(ACT_ALLOC, 12, 0, 0);
    send_op(ACT_ALLOC, 4, 0, 0);
    send_op(ACT_QUERY, 0, 0, 4);
    send_op(ACT_RELEASE, 0, 0, 4);
    send_op(ACT_ALLOC, 2, 3, 0);
    write_region(17'd5);
    send_op(ACT_ALLOC, 1, 0, 0);
    send_op(ACT_RELEASE, 0, 0, 4);
    send_op(ACT_QUERY, 0, 0, 4);
  endtask

  task automatic test_random_full;
    write_region(17'h1FFFF);
    for (int i = 0; i < 350; i++) begin
      steady_flow = (i >= 100 && i < 160);
      random_item(8000);
    end
    steady_flow = 0;
  endtask

  task automatic test_backpressure;
    hold_requests++;
    for (int i = 0; i < 60; i++) random_item(64);
  endtask

  task automatic test_random_sized;
    write_region(17'(($urandom_range(128, 30000)) | 1));
    for (int i = 0; i < 250; i++) random_item(4000);
    write_region(17'd256);
    for (int i = 0; i < 150; i++) random_item(300);
  endtask

  always @(posedge clk) begin
    heap_rsp_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: tdata=%h tuser=%b", m_tdata, m_tuser);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[15:0] !== exp_r.addr || m_tuser !== exp_r.failed ||
            m_tdata[31:16] !== exp_r.usable) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: addr exp %h got %h, failed exp %b got %b, usable exp %h got %h",
                     exp_r.addr, m_tdata[15:0], exp_r.failed, m_tuser,
                     exp_r.usable, m_tdata[31:16]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= 500;
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else begin
      m_tready <= steady_flow || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    heap_rebuild(REGION_BYTES_MAX);
    repeat (8) @(posedge clk);
    rst <= 0;
    test_directed();
    test_tiny_regions();
    test_random_full();
    test_backpressure();
    test_random_sized();
    drain();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ram.sv
hw/rtl/ffha_field.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_core.sv
tb/tb_top.sv
